// ===== hdl/cia_pkg.sv =====
// Package for the complex integer ALU: command codes, widths and shared types.
// No dependencies.
package cia_pkg;

   localparam int PART_WIDTH_DEFAULT = 32;
   localparam int FIFO_DEPTH = 4;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_EQ  = 3'd4,
      CMD_NE  = 3'd5
   } command_type;

   typedef enum logic [1:0] {
      OP_ADDSUB = 2'd0,
      OP_MUL    = 2'd1,
      OP_DIV    = 2'd2,
      OP_CMP    = 2'd3
   } op_class_type;

   // front-end classification passed through the queue
   typedef struct packed {
      op_class_type op_class;
      logic         subtract;
      logic         cmp_true;
      logic         unused_cmd;
   } class_type;

endpackage

// ===== hdl/cia_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read data.
// No dependencies.
module cia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// ===== hdl/cia_front.sv =====
// Front end: accepts beats, classifies the command, registers operands.
// Depends on cia_pkg.
module cia_front import cia_pkg::*; #(
   parameter int PART_WIDTH = PART_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [2:0]            in_command,
   input  logic [PART_WIDTH-1:0] in_a_real,
   input  logic [PART_WIDTH-1:0] in_a_imag,
   input  logic [PART_WIDTH-1:0] in_b_real,
   input  logic [PART_WIDTH-1:0] in_b_imag,
   input  logic                  out_ready,
   output logic                  in_ready,
   output logic                  out_valid,
   output class_type             out_class,
   output logic [4*PART_WIDTH-1:0] out_operands
);
   logic                    valid_ff, valid_in;
   class_type               class_ff, class_in;
   logic [4*PART_WIDTH-1:0] opnd_ff;
   logic                    equal;

   assign in_ready = !valid_ff || out_ready;
   assign equal = (in_a_real == in_b_real) && (in_a_imag == in_b_imag);

   always_comb begin
      class_in = '{op_class: OP_CMP, subtract: 1'b0, cmp_true: 1'b0, unused_cmd: 1'b0};
      case (in_command)
         CMD_ADD: class_in.op_class = OP_ADDSUB;
         CMD_SUB: begin
            class_in.op_class = OP_ADDSUB;
            class_in.subtract = 1'b1;
         end
         CMD_MUL: class_in.op_class = OP_MUL;
         CMD_DIV: class_in.op_class = OP_DIV;
         CMD_EQ:  class_in.cmp_true = equal;
         CMD_NE:  class_in.cmp_true = !equal;
         default: class_in.unused_cmd = 1'b1;
      endcase
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         class_ff <= class_in;
         opnd_ff  <= {in_a_real, in_a_imag, in_b_real, in_b_imag};
      end
   end

   assign out_valid    = valid_ff;
   assign out_class    = class_ff;
   assign out_operands = opnd_ff;
endmodule

// ===== hdl/cia_queue.sv =====
// Short first-word fall-through FIFO on cia_ram, used after the front and the back end.
// Depends on cia_pkg and cia_ram.
module cia_queue import cia_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             in_ready,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   input  logic             out_ready
);
   localparam int AW = $clog2(FIFO_DEPTH);

   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          ovalid_ff, ovalid_in;
   logic          push, pop_mem, load;
   logic [WIDTH-1:0] rd_data;

   // count_ff counts entries in the RAM, excluding the output register
   assign in_ready = count_ff < (AW+1)'(FIFO_DEPTH);
   assign push     = in_valid && in_ready;
   assign load     = !ovalid_ff || out_ready;
   assign pop_mem  = load && (count_ff != '0);

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop_mem ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (AW+1)'(push) - (AW+1)'(pop_mem);
   assign ovalid_in = load ? pop_mem : ovalid_ff;

   cia_ram #(.WIDTH(WIDTH), .DEPTH(FIFO_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (push),
      .wr_addr(wr_ptr_ff),
      .wr_data(in_data),
      .rd_en  (pop_mem),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign out_valid = ovalid_ff;
   assign out_data  = rd_data;
endmodule

// ===== hdl/cia_back.sv =====
// Back end: pipelined add/sub, multiply and radix-2 restoring divide, with
// valid/ready stalling of the whole pipe. Depends on cia_pkg.
module cia_back import cia_pkg::*; #(
   parameter int PART_WIDTH = PART_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  class_type             in_class,
   input  logic [4*PART_WIDTH-1:0] in_operands,
   output logic                  in_ready,
   output logic                  out_valid,
   output logic [PART_WIDTH-1:0] out_real,
   output logic [PART_WIDTH-1:0] out_imag,
   output logic                  out_cmp,
   output logic                  out_err,
   input  logic                  out_ready
);
   localparam int W = PART_WIDTH;
   localparam int NS = W + 3;   // mul0, mul1, prep, W divide steps

   typedef struct packed {
      class_type   cls;
      logic        err;
      logic        neg_r;
      logic        neg_i;
      logic [W-1:0] x0;   // b real / remainder real
      logic [W-1:0] x1;   // remainder imag
      logic [W-1:0] q0;   // quotient / result real
      logic [W-1:0] q1;
      logic [W-1:0] p0;   // products / denominator
      logic [W-1:0] p1;
      logic [W-1:0] p2;
      logic [W-1:0] p3;
   } stage_type;

   logic      adv;
   logic      v_ff [NS];
   stage_type s_ff [NS];
   stage_type s_in [NS];

   logic [W-1:0] ar, ai, br, bi;
   assign {ar, ai, br, bi} = in_operands;

   assign adv      = !v_ff[NS-1] || out_ready;
   assign in_ready = adv;

   // stage 0: add/sub results, or products (ar*br, ai*bi, ar*bi, ai*br) for mul and div
   always_comb begin
      s_in[0] = '0;
      s_in[0].cls = in_class;
      case (in_class.op_class)
         OP_ADDSUB: begin
            s_in[0].q0 = in_class.subtract ? ar - br : ar + br;
            s_in[0].q1 = in_class.subtract ? ai - bi : ai + bi;
         end
         OP_MUL, OP_DIV: begin
            s_in[0].p0 = W'(ar * br);
            s_in[0].p1 = W'(ai * bi);
            s_in[0].p2 = W'(ar * bi);
            s_in[0].p3 = W'(ai * br);
            s_in[0].x0 = br;
            s_in[0].x1 = bi;
         end
         default: ;
      endcase
   end

   // stage 1: combine products; squares for divide denominator
   always_comb begin
      s_in[1] = s_ff[0];
      case (s_ff[0].cls.op_class)
         OP_MUL: begin
            s_in[1].q0 = s_ff[0].p0 - s_ff[0].p1;
            s_in[1].q1 = s_ff[0].p2 + s_ff[0].p3;
         end
         OP_DIV: begin
            s_in[1].q0 = s_ff[0].p0 + s_ff[0].p1;
            s_in[1].q1 = s_ff[0].p3 - s_ff[0].p2;
            s_in[1].p0 = W'(s_ff[0].x0 * s_ff[0].x0);
            s_in[1].p1 = W'(s_ff[0].x1 * s_ff[0].x1);
         end
         default: ;
      endcase
   end

   // stage 2: denominator, signs, magnitudes
   always_comb begin
      logic [W-1:0] den;
      den = s_ff[1].p0 + s_ff[1].p1;
      s_in[2] = s_ff[1];
      if (s_ff[1].cls.op_class == OP_DIV) begin
         s_in[2].err   = (den == '0);
         s_in[2].neg_r = s_ff[1].q0[W-1] ^ den[W-1];
         s_in[2].neg_i = s_ff[1].q1[W-1] ^ den[W-1];
         s_in[2].q0    = s_ff[1].q0[W-1] ? -s_ff[1].q0 : s_ff[1].q0;
         s_in[2].q1    = s_ff[1].q1[W-1] ? -s_ff[1].q1 : s_ff[1].q1;
         s_in[2].p0    = den[W-1] ? -den : den;
         s_in[2].x0    = '0;
         s_in[2].x1    = '0;
      end
   end

   // stages 3..W+2: one restoring divide step each; q shifts in quotient bits
   for (genvar k = 3; k < NS; k++) begin : g_div
      always_comb begin
         logic [W:0] t0, t1;
         t0 = {s_ff[k-1].x0, s_ff[k-1].q0[W-1]};
         t1 = {s_ff[k-1].x1, s_ff[k-1].q1[W-1]};
         s_in[k] = s_ff[k-1];
         if (s_ff[k-1].cls.op_class == OP_DIV) begin
            if (t0 >= {1'b0, s_ff[k-1].p0}) begin
               s_in[k].x0 = W'(t0 - {1'b0, s_ff[k-1].p0});
               s_in[k].q0 = {s_ff[k-1].q0[W-2:0], 1'b1};
            end else begin
               s_in[k].x0 = W'(t0);
               s_in[k].q0 = {s_ff[k-1].q0[W-2:0], 1'b0};
            end
            if (t1 >= {1'b0, s_ff[k-1].p0}) begin
               s_in[k].x1 = W'(t1 - {1'b0, s_ff[k-1].p0});
               s_in[k].q1 = {s_ff[k-1].q1[W-2:0], 1'b1};
            end else begin
               s_in[k].x1 = W'(t1);
               s_in[k].q1 = {s_ff[k-1].q1[W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) v_ff[k] <= v_ff[k-1];
      end
      if (adv) begin
         s_ff[0] <= s_in[0];
         for (int k = 1; k < NS; k++) s_ff[k] <= s_in[k];
      end
   end

   stage_type f;
   assign f = s_ff[NS-1];

   always_comb begin
      out_real = '0;
      out_imag = '0;
      out_cmp  = 1'b0;
      out_err  = 1'b0;
      if (f.cls.unused_cmd) begin
         out_real = '0;
      end else if (f.cls.op_class == OP_CMP) begin
         out_cmp = f.cls.cmp_true;
      end else if (f.cls.op_class == OP_DIV) begin
         out_err = f.err;
         if (!f.err) begin
            out_real = f.neg_r ? -f.q0 : f.q0;
            out_imag = f.neg_i ? -f.q1 : f.q1;
         end
      end else begin
         out_real = f.q0;
         out_imag = f.q1;
      end
   end

   assign out_valid = v_ff[NS-1];
endmodule

// ===== hdl/complex_integer_alu_top.sv =====
// Top level of the complex integer ALU: front end, queue, back end.
// Depends on cia_pkg, cia_front, cia_queue, cia_back.
//
// Usage: push a beat (command, a, b) when full is low; results come out in
// order and wait on rsp_ ports while empty is low until pop.
// Commands: add, subtract, multiply, divide, equal, not equal.
// Throughput: one beat per cycle while pop keeps up, set by the fully
// pipelined back end (one restoring divide step per stage for each part).
// Path from push to empty going low: front register, queue RAM read, two
// multiply stages, sign stage, PART_WIDTH divide stages, output queue;
// every command takes the same path so order is kept.
// Divide by a zero wrapped |b|^2 sets rsp_divide_error with zero parts.
// Reset (synchronous) empties all stages and queues.
// When the receiver stops popping, the output queue fills, the back end
// stalls, then the middle queue fills and full rises; nothing is dropped.
module complex_integer_alu_top import cia_pkg::*; #(
   parameter int PART_WIDTH = PART_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [2:0]            req_command,
   input  logic [PART_WIDTH-1:0] req_a_real,
   input  logic [PART_WIDTH-1:0] req_a_imag,
   input  logic [PART_WIDTH-1:0] req_b_real,
   input  logic [PART_WIDTH-1:0] req_b_imag,
   output logic                  empty,
   input  logic                  pop,
   output logic [PART_WIDTH-1:0] rsp_result_real,
   output logic [PART_WIDTH-1:0] rsp_result_imag,
   output logic                  rsp_compare_true,
   output logic                  rsp_divide_error
);
   localparam int QW = $bits(class_type) + 4*PART_WIDTH;
   localparam int RW = 2*PART_WIDTH + 2;

   logic front_ready, front_valid, q_ready, q_valid, back_ready, back_valid, o_ready, o_valid;
   class_type front_class, q_class;
   logic [4*PART_WIDTH-1:0] front_opnd, q_opnd;
   logic [QW-1:0] q_out;
   logic [PART_WIDTH-1:0] b_real, b_imag;
   logic b_cmp, b_err;
   logic [RW-1:0] o_data;

   assign full = !front_ready;

   cia_front #(.PART_WIDTH(PART_WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(push), .in_command(req_command),
      .in_a_real(req_a_real), .in_a_imag(req_a_imag),
      .in_b_real(req_b_real), .in_b_imag(req_b_imag),
      .out_ready(q_ready), .in_ready(front_ready),
      .out_valid(front_valid), .out_class(front_class), .out_operands(front_opnd)
   );

   cia_queue #(.WIDTH(QW)) u_mid (
      .clock(clock), .reset(reset),
      .in_valid(front_valid), .in_data({front_class, front_opnd}), .in_ready(q_ready),
      .out_valid(q_valid), .out_data(q_out), .out_ready(back_ready)
   );

   assign {q_class, q_opnd} = q_out;

   cia_back #(.PART_WIDTH(PART_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_class(q_class), .in_operands(q_opnd), .in_ready(back_ready),
      .out_valid(back_valid), .out_real(b_real), .out_imag(b_imag),
      .out_cmp(b_cmp), .out_err(b_err), .out_ready(o_ready)
   );

   cia_queue #(.WIDTH(RW)) u_out (
      .clock(clock), .reset(reset),
      .in_valid(back_valid), .in_data({b_real, b_imag, b_cmp, b_err}), .in_ready(o_ready),
      .out_valid(o_valid), .out_data(o_data), .out_ready(pop)
   );

   assign empty = !o_valid;
   assign {rsp_result_real, rsp_result_imag, rsp_compare_true, rsp_divide_error} = o_data;
endmodule

// ===== tb/tb.sv =====
// Testbench for complex_integer_alu_top: directed and random beats, checked against
// an in-bench predictor of Gaussian integer add/sub/mul/div/compare.
// Depends on cia_pkg and the complex_integer_alu_top RTL.
`timescale 1ns / 1ps

module tb;
   import cia_pkg::*;

   localparam int W = 32;
   localparam int LATENCY = W + 7;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic [W-1:0] part_type;

   typedef struct packed {
      part_type rr;
      part_type ri;
      logic     cmp;
      logic     err;
   } alu_result_type;

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic pop = 0;
   logic [2:0] req_command = '0;
   part_type req_a_real = '0, req_a_imag = '0, req_b_real = '0, req_b_imag = '0;
   logic full, empty;
   part_type rsp_result_real, rsp_result_imag;
   logic rsp_compare_true, rsp_divide_error;

   alu_result_type pending_results[$];
   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   longint cycle_count = 0;
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   bit hold_pop = 0;
   int div_errors_seen = 0;

   always #2 clock = ~clock;

   complex_integer_alu_top #(.PART_WIDTH(W)) dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_command(req_command), .req_a_real(req_a_real), .req_a_imag(req_a_imag),
      .req_b_real(req_b_real), .req_b_imag(req_b_imag),
      .empty(empty), .pop(pop),
      .rsp_result_real(rsp_result_real), .rsp_result_imag(rsp_result_imag),
      .rsp_compare_true(rsp_compare_true), .rsp_divide_error(rsp_divide_error)
   );

   function automatic part_type trunc_div(part_type num, part_type den);
      logic nn, dn;
      part_type an, ad, q;
      nn = num[W-1];
      dn = den[W-1];
      an = nn ? -num : num;
      ad = dn ? -den : den;
      q = an / ad;
      return (nn != dn) ? -q : q;
   endfunction

   function automatic alu_result_type complex_alu_result(logic [2:0] cmd, part_type ar,
                                                         part_type ai, part_type br,
                                                         part_type bi);
      alu_result_type r;
      part_type den;
      r = '0;
      case (cmd)
         CMD_ADD: begin
            r.rr = ar + br;
            r.ri = ai + bi;
         end
         CMD_SUB: begin
            r.rr = ar - br;
            r.ri = ai - bi;
         end
         CMD_MUL: begin
            r.rr = ar * br - ai * bi;
            r.ri = ar * bi + ai * br;
         end
         CMD_DIV: begin
            den = br * br + bi * bi;
            if (den == '0) begin
               r.err = 1'b1;
            end else begin
               r.rr = trunc_div(ar * br + ai * bi, den);
               r.ri = trunc_div(ai * br - ar * bi, den);
            end
         end
         CMD_EQ: r.cmp = (ar == br) && (ai == bi);
         CMD_NE: r.cmp = !((ar == br) && (ai == bi));
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
      $display("MISMATCH beat %0d %s: got %h want %h", beats_checked, what, got, want);
      errors++;
   endtask

   task automatic send_beat(logic [2:0] cmd, part_type ar, part_type ai, part_type br,
                            part_type bi);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_command <= cmd;
      req_a_real <= ar;
      req_a_imag <= ai;
      req_b_real <= br;
      req_b_imag <= bi;
      pending_results.push_back(complex_alu_result(cmd, ar, ai, br, bi));
      beats_sent++;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // result checker: sample at the edge, then decide next pop
   always @(posedge clock) begin
      alu_result_type want;
      cycle_count++;
      if (!reset && pop && !empty) begin
         beats_checked++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", '0, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_real !== want.rr) report_mismatch("real", rsp_result_real, want.rr);
            if (rsp_result_imag !== want.ri) report_mismatch("imag", rsp_result_imag, want.ri);
            if (rsp_compare_true !== want.cmp)
               report_mismatch("compare", W'(rsp_compare_true), W'(want.cmp));
            if (rsp_divide_error !== want.err)
               report_mismatch("div_err", W'(rsp_divide_error), W'(want.err));
            if (want.err) div_errors_seen++;
         end
      end
      if (reset || hold_pop) pop <= 1'b0;
      else pop <= !(pop_stall_pct > 0 && $urandom_range(99) < pop_stall_pct);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
   end

   function automatic part_type rand_part();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return part_type'($urandom_range(0, 6)) - 3;
         3: return 32'h0001_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      part_type ext[6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                           32'h5555_aaaa};
      for (int c = 0; c < 8; c++)
         send_beat(c[2:0], ext[c % 6], ext[(c + 3) % 6], ext[(c + 4) % 6], ext[(c + 1) % 6]);
      send_beat(CMD_DIV, 32'd7, 32'd3, 32'd0, 32'd0);
      send_beat(CMD_DIV, 32'd7, 32'd3, 32'h0001_0000, 32'd0);
      send_beat(CMD_DIV, 32'h8000_0000, 32'd0, 32'hffff_ffff, 32'd0);
      send_beat(CMD_DIV, -32'sd7, 32'd9, 32'd2, 32'd1);
      send_beat(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_beat(CMD_EQ, 32'd5, 32'd6, 32'd5, 32'd6);
      send_beat(CMD_NE, 32'd5, 32'd6, 32'd5, 32'd6);
      send_beat(CMD_EQ, 32'd5, 32'd6, 32'd5, 32'd7);
      send_beat(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'hffff_ffff);
      send_beat(CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'hffff_ffff);
      send_beat(3'd6, 32'd1, 32'd2, 32'd3, 32'd4);
      send_beat(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      wait_drained();
   endtask

   task automatic send_random_beats(int n);
      logic [2:0] cmd;
      part_type ar, ai;
      for (int i = 0; i < n; i++) begin
         cmd = $urandom_range(99) < 4 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
         ar = rand_part();
         ai = rand_part();
         if (cmd inside {CMD_EQ, CMD_NE} && $urandom_range(1)) send_beat(cmd, ar, ai, ar, ai);
         else send_beat(cmd, ar, ai, rand_part(), rand_part());
      end
   endtask

   task automatic test_random_phases();
      int idle[4] = '{0, 82, 0, 17};
      int stall[4] = '{0, 0, 82, 17};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle[p];
         pop_stall_pct = stall[p];
         send_random_beats(300);
         wait_drained();
      end
      send_idle_pct = 0;
      pop_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_pop = 1;
            repeat (3 * LATENCY) @(posedge clock);
            hold_pop = 0;
         end
         send_random_beats(150);
      join
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phases();
      test_backpressure();
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d beats, %0d results checked, %0d zero-denominator divides",
               beats_sent, beats_checked, div_errors_seen);
      $display("phases: directed, idle/stall mixes, long receiver hold-off");
      if (errors == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hdl/cia_pkg.sv
hdl/cia_ram.sv
hdl/cia_front.sv
hdl/cia_queue.sv
hdl/cia_back.sv
hdl/complex_integer_alu_top.sv
tb/tb.sv
